[rtl/ares_pkg.sv]
// Shared types, widths and the control program of the adaptive-rate smoother.
// Depends on nothing; the sequencer and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package ares_pkg;

   // Field widths.
   localparam int SAMPLE_W = 24;
   localparam int FRAC_W   = 16;
   localparam int LEVEL_W  = SAMPLE_W + FRAC_W;
   localparam int ERR_W    = LEVEL_W + 1;
   localparam int RATE_W   = FRAC_W + 1;
   localparam int ALPHA_W  = 17;

   // Fixed point one and the alpha value after reset (0.3 rounded).
   localparam logic [RATE_W-1:0]  ONE_FX      = RATE_W'(1) << FRAC_W;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(19661);

   // Partial product split of the 41 bit operands: a low and a high slice.
   localparam int LO_W   = 24;
   localparam int HI_W   = ERR_W - LO_W;
   localparam int MB_W   = LO_W + 1;
   localparam int MA_W   = ALPHA_W + 1;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = 60;

   // Divider widths and step count.
   localparam int REM_W     = ERR_W + 1;
   localparam int DIV_STEPS = RATE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Program counter and the jump targets of the program.
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_DIV   = PC_W'(14);
   localparam logic [PC_W-1:0] PC_RZERO = PC_W'(16);
   localparam logic [PC_W-1:0] PC_RONE  = PC_W'(17);
   localparam logic [PC_W-1:0] PC_LVL   = PC_W'(18);
   localparam logic [PC_W-1:0] PC_DONE  = PC_W'(22);
   localparam logic [PC_W-1:0] PC_FIRST = PC_W'(23);

   typedef enum logic [1:0] {
      MA_ALPHA = 2'd0,
      MA_BETA  = 2'd1,
      MA_RATE  = 2'd2
   } mula_sel_type;

   typedef enum logic [2:0] {
      MB_E_LO  = 3'd0,
      MB_E_HI  = 3'd1,
      MB_Q_LO  = 3'd2,
      MB_Q_HI  = 3'd3,
      MB_AE_LO = 3'd4,
      MB_AE_HI = 3'd5,
      MB_D_LO  = 3'd6,
      MB_D_HI  = 3'd7
   } mulb_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [3:0] {
      WR_NONE      = 4'd0,
      WR_ERR       = 4'd1,
      WR_ABS       = 4'd2,
      WR_Q         = 4'd3,
      WR_D_ABSQ    = 4'd4,
      WR_DIV_INIT  = 4'd5,
      WR_DIV_STEP  = 4'd6,
      WR_RATE_QUO  = 4'd7,
      WR_RATE_ZERO = 4'd8,
      WR_RATE_ONE  = 4'd9,
      WR_LEVEL     = 4'd10,
      WR_FIRST     = 4'd11,
      WR_OUT       = 4'd12
   } wr_op_type;

   typedef enum logic [2:0] {
      C_NONE        = 3'd0,
      C_ALWAYS      = 3'd1,
      C_NOT_STARTED = 3'd2,
      C_D_ZERO      = 3'd3,
      C_BIG         = 3'd4,
      C_DIV_MORE    = 3'd5,
      C_OUT_BUSY    = 3'd6
   } cond_type;

   // One control word of the program.
   typedef struct packed {
      logic             mul_en;
      mula_sel_type     mul_a;
      mulb_sel_type     mul_b;
      logic             mul_sh;
      acc_op_type       acc_op;
      wr_op_type        wr;
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic             last;
   } ctrl_type;

   // Datapath flags the program branches on.
   typedef struct packed {
      logic not_started;
      logic d_zero;
      logic big;
      logic div_more;
      logic out_busy;
   } status_type;

   localparam ctrl_type CTRL_NOP = '{
      mul_en: 1'b0, mul_a: MA_ALPHA, mul_b: MB_E_LO, mul_sh: 1'b0,
      acc_op: ACC_HOLD, wr: WR_NONE, cond: C_NONE, target: '0, last: 1'b0
   };

   // The program. Multiplies overlap: each step that follows a multiplying step
   // loads or adds the product of that step into the accumulator.
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (pc)
         PC_W'(0): begin
            w.wr = WR_ERR; w.cond = C_NOT_STARTED; w.target = PC_FIRST;
         end
         PC_W'(1): begin
            w.wr = WR_ABS; w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = MB_E_LO;
         end
         PC_W'(2): begin
            w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = MB_E_HI; w.mul_sh = 1'b1;
            w.acc_op = ACC_LOAD;
         end
         PC_W'(3): begin
            w.mul_en = 1'b1; w.mul_a = MA_BETA; w.mul_b = MB_Q_LO; w.acc_op = ACC_ADD;
         end
         PC_W'(4): begin
            w.mul_en = 1'b1; w.mul_a = MA_BETA; w.mul_b = MB_Q_HI; w.mul_sh = 1'b1;
            w.acc_op = ACC_ADD;
         end
         PC_W'(5): w.acc_op = ACC_ADD;
         PC_W'(6): begin
            w.wr = WR_Q; w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = MB_AE_LO;
         end
         PC_W'(7): begin
            w.mul_en = 1'b1; w.mul_a = MA_ALPHA; w.mul_b = MB_AE_HI; w.mul_sh = 1'b1;
            w.acc_op = ACC_LOAD;
         end
         PC_W'(8): begin
            w.mul_en = 1'b1; w.mul_a = MA_BETA; w.mul_b = MB_D_LO; w.acc_op = ACC_ADD;
         end
         PC_W'(9): begin
            w.mul_en = 1'b1; w.mul_a = MA_BETA; w.mul_b = MB_D_HI; w.mul_sh = 1'b1;
            w.acc_op = ACC_ADD;
         end
         PC_W'(10): w.acc_op = ACC_ADD;
         PC_W'(11): w.wr = WR_D_ABSQ;
         PC_W'(12): begin
            w.wr = WR_DIV_INIT; w.cond = C_D_ZERO; w.target = PC_RZERO;
         end
         PC_W'(13): begin
            w.cond = C_BIG; w.target = PC_RONE;
         end
         PC_W'(14): begin
            w.wr = WR_DIV_STEP; w.cond = C_DIV_MORE; w.target = PC_DIV;
         end
         PC_W'(15): begin
            w.wr = WR_RATE_QUO; w.cond = C_ALWAYS; w.target = PC_LVL;
         end
         PC_W'(16): begin
            w.wr = WR_RATE_ZERO; w.cond = C_ALWAYS; w.target = PC_LVL;
         end
         PC_W'(17): w.wr = WR_RATE_ONE;
         PC_W'(18): begin
            w.mul_en = 1'b1; w.mul_a = MA_RATE; w.mul_b = MB_E_LO;
         end
         PC_W'(19): begin
            w.mul_en = 1'b1; w.mul_a = MA_RATE; w.mul_b = MB_E_HI; w.mul_sh = 1'b1;
            w.acc_op = ACC_LOAD;
         end
         PC_W'(20): w.acc_op = ACC_ADD;
         PC_W'(21): w.wr = WR_LEVEL;
         PC_W'(22): begin
            w.wr = WR_OUT; w.cond = C_OUT_BUSY; w.target = PC_DONE; w.last = 1'b1;
         end
         PC_W'(23): begin
            w.wr = WR_FIRST; w.cond = C_ALWAYS; w.target = PC_DONE;
         end
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

endpackage

[rtl/adaptive_rate_exp_smoother_unit.sv]
// Top level of the adaptive-rate exponential smoother: datapath and channels.
// Depends on ares_pkg and on the program sequencer ares_seq.
`timescale 1ns / 1ps

// Usage
// The req_ channel carries one signed sample per transaction; the rsp_ channel
// returns one result per sample: first-sample flag, level, rate, forecast
// error, smoothed error and mean absolute error, all with 16 fraction bits.
// The csr_ channel writes alpha (17 bits, 16 fraction bits); csr_ready is
// always high, and writes belong in idle periods.
// A microcoded sequencer steps one multiplier (18 x 25 bits, one partial
// product per step), an accumulator and a one-bit-per-step divider.
// The first sample after reset takes a short path; a later sample runs the
// normal path through the divider loop, or skips that loop when the rate is
// clamped or zero.
// One sample is in work at a time; req_stall is high while it runs, so the
// next sample is taken only once the last one has left its last step.
// Reset restores alpha to 0.3 and clears level, Q, D and the started flag.
// A result waits in the output register while rsp_stall is high; the
// next sample still runs and holds in its last step until that register
// is free.
module adaptive_rate_exp_smoother_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ares_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_first_sample,
   output logic signed [ares_pkg::LEVEL_W-1:0]   rsp_level,
   output logic        [ares_pkg::RATE_W-1:0]    rsp_rate,
   output logic signed [ares_pkg::ERR_W-1:0]     rsp_forecast_error,
   output logic signed [ares_pkg::ERR_W-1:0]     rsp_smoothed_err,
   output logic        [ares_pkg::LEVEL_W-1:0]   rsp_mean_abs_err,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [ares_pkg::ALPHA_W-1:0]   csr_wdata
);

   localparam int F  = ares_pkg::FRAC_W;
   localparam int LO = ares_pkg::LO_W;

   ares_pkg::ctrl_type   ctrl;
   ares_pkg::status_type status;
   logic                 busy;
   logic                 start;

   logic [ares_pkg::ALPHA_W-1:0]         alpha_ff, alpha_in;
   logic [ares_pkg::SAMPLE_W-1:0]        sample_ff, sample_in;
   logic                                 started_ff, started_in;
   logic                                 first_ff, first_in;
   logic [ares_pkg::LEVEL_W-1:0]         level_ff, level_in;
   logic [ares_pkg::ERR_W-1:0]           q_ff, q_in;
   logic [ares_pkg::ERR_W-1:0]           d_ff, d_in;
   logic [ares_pkg::ERR_W-1:0]           e_ff, e_in;
   logic [ares_pkg::ERR_W-1:0]           abse_ff, abse_in;
   logic [ares_pkg::ERR_W-1:0]           absq_ff, absq_in;
   logic [ares_pkg::RATE_W-1:0]          rate_ff, rate_in;
   logic signed [ares_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                                 prod_sh_ff, prod_sh_in;
   logic signed [ares_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [ares_pkg::REM_W-1:0]           rem_ff, rem_in;
   logic [ares_pkg::RATE_W-1:0]          quo_ff, quo_in;
   logic [ares_pkg::CNT_W-1:0]           cnt_ff, cnt_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_first_ff, rsp_first_in;
   logic [ares_pkg::LEVEL_W-1:0]         rsp_level_ff, rsp_level_in;
   logic [ares_pkg::RATE_W-1:0]          rsp_rate_ff, rsp_rate_in;
   logic [ares_pkg::ERR_W-1:0]           rsp_err_ff, rsp_err_in;
   logic [ares_pkg::ERR_W-1:0]           rsp_q_ff, rsp_q_in;
   logic [ares_pkg::LEVEL_W-1:0]         rsp_d_ff, rsp_d_in;

   logic [ares_pkg::ALPHA_W-1:0]         alpha_sat;
   logic [ares_pkg::ALPHA_W-1:0]         beta;
   logic [ares_pkg::ALPHA_W-1:0]         mul_a;
   logic signed [ares_pkg::MB_W-1:0]     mul_b;
   logic signed [ares_pkg::ACC_W-1:0]    term;
   logic [ares_pkg::ERR_W-1:0]           diff;
   logic                                 div_ge;
   logic [ares_pkg::REM_W-1:0]           rem_sub;
   logic                                 out_busy;

   assign start     = req_valid && !busy;
   assign req_stall = busy;
   assign csr_ready = 1'b1;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   ares_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   // Flags the program branches on.
   always_comb begin
      status.not_started = !started_ff;
      status.d_zero      = (d_ff == '0);
      status.big         = {1'b0, absq_ff} >= {d_ff, 1'b0};
      status.div_more    = (cnt_ff != ares_pkg::CNT_W'(ares_pkg::DIV_STEPS - 1));
      status.out_busy    = out_busy;
   end

   // Alpha saturates at one; beta is one minus alpha.
   assign alpha_sat = (alpha_ff > ares_pkg::ONE_FX) ? ares_pkg::ONE_FX : alpha_ff;
   assign beta      = ares_pkg::ONE_FX - alpha_sat;

   // Multiplier operand selection: a weight times one slice of a wide value.
   always_comb begin
      unique case (ctrl.mul_a)
         ares_pkg::MA_ALPHA: mul_a = alpha_sat;
         ares_pkg::MA_BETA:  mul_a = beta;
         ares_pkg::MA_RATE:  mul_a = rate_ff;
         default:            mul_a = alpha_sat;
      endcase
      unique case (ctrl.mul_b)
         ares_pkg::MB_E_LO:  mul_b = {1'b0, e_ff[LO-1:0]};
         ares_pkg::MB_E_HI:  mul_b = {{(ares_pkg::MB_W - ares_pkg::HI_W){e_ff[ares_pkg::ERR_W-1]}},
                                      e_ff[ares_pkg::ERR_W-1:LO]};
         ares_pkg::MB_Q_LO:  mul_b = {1'b0, q_ff[LO-1:0]};
         ares_pkg::MB_Q_HI:  mul_b = {{(ares_pkg::MB_W - ares_pkg::HI_W){q_ff[ares_pkg::ERR_W-1]}},
                                      q_ff[ares_pkg::ERR_W-1:LO]};
         ares_pkg::MB_AE_LO: mul_b = {1'b0, abse_ff[LO-1:0]};
         ares_pkg::MB_AE_HI: mul_b = {{(ares_pkg::MB_W - ares_pkg::HI_W){1'b0}},
                                      abse_ff[ares_pkg::ERR_W-1:LO]};
         ares_pkg::MB_D_LO:  mul_b = {1'b0, d_ff[LO-1:0]};
         ares_pkg::MB_D_HI:  mul_b = {{(ares_pkg::MB_W - ares_pkg::HI_W){1'b0}},
                                      d_ff[ares_pkg::ERR_W-1:LO]};
         default:            mul_b = '0;
      endcase
   end

   assign prod_in    = ctrl.mul_en ? (ares_pkg::PROD_W'($signed({1'b0, mul_a}))
                                      * ares_pkg::PROD_W'(mul_b)) : prod_ff;
   assign prod_sh_in = ctrl.mul_en ? ctrl.mul_sh : prod_sh_ff;

   // Sign-extend the registered product and place it at its slice weight.
   always_comb begin
      term = {{(ares_pkg::ACC_W - ares_pkg::PROD_W){prod_ff[ares_pkg::PROD_W-1]}}, prod_ff};
      if (prod_sh_ff) begin
         term = term <<< LO;
      end
   end

   always_comb begin
      unique case (ctrl.acc_op)
         ares_pkg::ACC_HOLD: acc_in = acc_ff;
         ares_pkg::ACC_LOAD: acc_in = term;
         ares_pkg::ACC_ADD:  acc_in = acc_ff + term;
         default:            acc_in = acc_ff;
      endcase
   end

   // Forecast error: the sample scaled to fixed point minus the level.
   assign diff = {sample_ff[ares_pkg::SAMPLE_W-1], sample_ff, {F{1'b0}}}
               - {level_ff[ares_pkg::LEVEL_W-1], level_ff};

   // One restoring division step of the rate quotient.
   assign div_ge  = rem_ff >= {1'b0, d_ff};
   assign rem_sub = div_ge ? (rem_ff - {1'b0, d_ff}) : rem_ff;

   // Register writes selected by the control word.
   always_comb begin
      alpha_in     = alpha_ff;
      sample_in    = sample_ff;
      started_in   = started_ff;
      first_in     = first_ff;
      level_in     = level_ff;
      q_in         = q_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      abse_in      = abse_ff;
      absq_in      = absq_ff;
      rate_in      = rate_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_first_in = rsp_first_ff;
      rsp_level_in = rsp_level_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_q_in     = rsp_q_ff;
      rsp_d_in     = rsp_d_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         alpha_in = csr_wdata;
      end
      if (start) begin
         sample_in = req_sample;
      end

      unique case (ctrl.wr)
         ares_pkg::WR_NONE: begin
         end
         ares_pkg::WR_ERR: begin
            e_in     = diff;
            first_in = 1'b0;
         end
         ares_pkg::WR_ABS: begin
            abse_in = e_ff[ares_pkg::ERR_W-1] ? (~e_ff + ares_pkg::ERR_W'(1)) : e_ff;
         end
         ares_pkg::WR_Q: begin
            q_in = acc_ff[F+ares_pkg::ERR_W-1:F];
         end
         ares_pkg::WR_D_ABSQ: begin
            d_in    = acc_ff[F+ares_pkg::ERR_W-1:F];
            absq_in = q_ff[ares_pkg::ERR_W-1] ? (~q_ff + ares_pkg::ERR_W'(1)) : q_ff;
         end
         ares_pkg::WR_DIV_INIT: begin
            rem_in = {1'b0, absq_ff};
            quo_in = '0;
            cnt_in = '0;
         end
         ares_pkg::WR_DIV_STEP: begin
            rem_in = {rem_sub[ares_pkg::REM_W-2:0], 1'b0};
            quo_in = {quo_ff[ares_pkg::RATE_W-2:0], div_ge};
            cnt_in = cnt_ff + ares_pkg::CNT_W'(1);
         end
         ares_pkg::WR_RATE_QUO: begin
            rate_in = (quo_ff > ares_pkg::ONE_FX) ? ares_pkg::ONE_FX : quo_ff;
         end
         ares_pkg::WR_RATE_ZERO: begin
            rate_in = '0;
         end
         ares_pkg::WR_RATE_ONE: begin
            rate_in = ares_pkg::ONE_FX;
         end
         ares_pkg::WR_LEVEL: begin
            level_in = level_ff + acc_ff[F+ares_pkg::LEVEL_W-1:F];
         end
         ares_pkg::WR_FIRST: begin
            level_in   = {sample_ff, {F{1'b0}}};
            q_in       = '0;
            d_in       = '0;
            e_in       = '0;
            rate_in    = ares_pkg::ONE_FX;
            started_in = 1'b1;
            first_in   = 1'b1;
         end
         ares_pkg::WR_OUT: begin
            // Load the result once the output register is free.
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_first_in = first_ff;
               rsp_level_in = level_ff;
               rsp_rate_in  = rate_ff;
               rsp_err_in   = e_ff;
               rsp_q_in     = q_ff;
               rsp_d_in     = d_ff[ares_pkg::LEVEL_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Control state and smoother state, set by reset (alpha to 0.3, the rest to zero).
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ares_pkg::ALPHA_RESET;
         started_ff   <= 1'b0;
         level_ff     <= '0;
         q_ff         <= '0;
         d_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         started_ff   <= started_in;
         level_ff     <= level_in;
         q_ff         <= q_in;
         d_ff         <= d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      first_ff     <= first_in;
      e_ff         <= e_in;
      abse_ff      <= abse_in;
      absq_ff      <= absq_in;
      rate_ff      <= rate_in;
      prod_ff      <= prod_in;
      prod_sh_ff   <= prod_sh_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      rsp_first_ff <= rsp_first_in;
      rsp_level_ff <= rsp_level_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_q_ff     <= rsp_q_in;
      rsp_d_ff     <= rsp_d_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_first_sample   = rsp_first_ff;
   assign rsp_level          = rsp_level_ff;
   assign rsp_rate           = rsp_rate_ff;
   assign rsp_forecast_error = rsp_err_ff;
   assign rsp_smoothed_err   = rsp_q_ff;
   assign rsp_mean_abs_err   = rsp_d_ff;

endmodule

[rtl/ares_seq.sv]
// Program sequencer of the smoother: step counter, control ROM and jump logic.
// Depends on ares_pkg for the control word, the status flags and the program.
`timescale 1ns / 1ps

module ares_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  ares_pkg::status_type status,
   output ares_pkg::ctrl_type   ctrl,
   output logic                 busy
);

   logic [ares_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                      busy_ff, busy_in;
   ares_pkg::ctrl_type        word;
   logic                      jump;

   // Fetch the current control word; nothing runs while idle.
   always_comb begin
      word = busy_ff ? ares_pkg::ucode(pc_ff) : ares_pkg::CTRL_NOP;
   end

   // Evaluate the jump condition of the current word.
   always_comb begin
      unique case (word.cond)
         ares_pkg::C_NONE:        jump = 1'b0;
         ares_pkg::C_ALWAYS:      jump = 1'b1;
         ares_pkg::C_NOT_STARTED: jump = status.not_started;
         ares_pkg::C_D_ZERO:      jump = status.d_zero;
         ares_pkg::C_BIG:         jump = status.big;
         ares_pkg::C_DIV_MORE:    jump = status.div_more;
         ares_pkg::C_OUT_BUSY:    jump = status.out_busy;
         default:                 jump = 1'b0;
      endcase
   end

   // Next step and run flag.
   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = '0;
         end
      end else if (jump) begin
         pc_in = word.target;
      end else if (word.last) begin
         busy_in = 1'b0;
      end else begin
         pc_in = pc_ff + ares_pkg::PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign ctrl = word;
   assign busy = busy_ff;

endmodule
